[hw/rtl/odo_pkg.sv]
// odo_pkg: shared types, constants and helper functions of the odometry unit
`timescale 1ns / 1ps

package odo_pkg;

  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int POS_FRAC_BITS_DEF = 8;

  localparam int DEG2RAD_Q24 = 292818;
  localparam int RAD2DEG_Q16 = 3754936;
  localparam int TWO_PI_Q16  = 411775;
  localparam int PI_Q16      = 205887;
  localparam int HALF_PI_Q16 = 102944;
  localparam int GAIN_Q30    = 652032875;
  localparam int COUNT_CLAMP = 16777216;

  localparam logic [15:0] RADIUS_RST  = 16'd12800;
  localparam logic [17:0] SPACING_RST = 18'd38400;
  localparam logic [7:0]  CELLDIV_RST = 8'd3;

  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = 80;
  localparam int DIV_W   = 64;
  localparam int DIV_D_W = 19;
  localparam int DIV_C_W = 6;
  localparam int COR_W   = 34;
  localparam int COR_Z_W = 33;

  localparam logic [1:0] CFG_RADIUS  = 2'd0;
  localparam logic [1:0] CFG_SPACING = 2'd1;
  localparam logic [1:0] CFG_CELLDIV = 2'd2;

  localparam logic [1:0] CMD_UPDATE  = 2'd0;
  localparam logic [1:0] CMD_INIT    = 2'd1;
  localparam logic [1:0] CMD_CORRECT = 2'd2;
  localparam logic [1:0] CMD_SETLEN  = 2'd3;

  localparam logic [2:0] MODE_XYH = 3'd0;
  localparam logic [2:0] MODE_XY  = 3'd1;
  localparam logic [2:0] MODE_XH  = 3'd2;
  localparam logic [2:0] MODE_YH  = 3'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] right_count;
    logic signed [31:0] left_count;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_heading_deg;
    logic [2:0]         correct_mode;
    logic signed [31:0] new_length;
  } odo_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading_degrees;
    logic signed [31:0] travelled;
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
  } odo_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ISSUE,
    ST_WAIT,
    ST_FINISH
  } odo_state_t;

  typedef enum logic [3:0] {
    OP_SUMMUL,
    OP_DIFMUL,
    OP_DLMUL,
    OP_THMUL,
    OP_THDIV,
    OP_MOD,
    OP_CORDIC,
    OP_XMUL,
    OP_YMUL,
    OP_DEGMUL,
    OP_CXDIV,
    OP_CYDIV,
    OP_NHMUL
  } odo_op_t;

  typedef struct packed {
    logic    accept;
    logic    load;
    odo_op_t op;
    logic    start;
    logic    capture;
    logic    out_load;
  } odo_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       done;
  } odo_sts_t;

  function automatic logic op_is_last(odo_op_t op);
    return (op == OP_CYDIV) || (op == OP_NHMUL);
  endfunction

  function automatic odo_op_t next_op(odo_op_t op);
    odo_op_t n;
    n = OP_SUMMUL;
    unique case (op)
      OP_SUMMUL: n = OP_DIFMUL;
      OP_DIFMUL: n = OP_DLMUL;
      OP_DLMUL:  n = OP_THMUL;
      OP_THMUL:  n = OP_THDIV;
      OP_THDIV:  n = OP_MOD;
      OP_MOD:    n = OP_CORDIC;
      OP_CORDIC: n = OP_XMUL;
      OP_XMUL:   n = OP_YMUL;
      OP_YMUL:   n = OP_DEGMUL;
      OP_DEGMUL: n = OP_CXDIV;
      OP_CXDIV:  n = OP_CYDIV;
      default:   n = OP_SUMMUL;
    endcase
    return n;
  endfunction

  function automatic logic [31:0] atan_q30(logic [4:0] idx);
    logic [31:0] v;
    v = '0;
    unique case (idx)
      5'd0:  v = 32'd843314857;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043836;
      5'd3:  v = 32'd133525158;
      5'd4:  v = 32'd67021686;
      5'd5:  v = 32'd33543515;
      5'd6:  v = 32'd16775850;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194282;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048576;
      5'd11: v = 32'd524288;
      5'd12: v = 32'd262144;
      5'd13: v = 32'd131072;
      5'd14: v = 32'd65536;
      5'd15: v = 32'd32768;
      5'd16: v = 32'd16384;
      5'd17: v = 32'd8192;
      5'd18: v = 32'd4096;
      5'd19: v = 32'd2048;
      5'd20: v = 32'd1024;
      5'd21: v = 32'd512;
      5'd22: v = 32'd256;
      5'd23: v = 32'd128;
      5'd24: v = 32'd64;
      5'd25: v = 32'd32;
      5'd26: v = 32'd16;
      5'd27: v = 32'd8;
      5'd28: v = 32'd4;
      5'd29: v = 32'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [MUL_P_W-1:0] v);
    logic signed [31:0] r;
    if (v[MUL_P_W-1:31] == {(MUL_P_W-31){v[MUL_P_W-1]}}) begin
      r = v[31:0];
    end else if (v[MUL_P_W-1]) begin
      r = 32'sh80000000;
    end else begin
      r = 32'sh7fffffff;
    end
    return r;
  endfunction

  function automatic logic signed [MUL_P_W-1:0] rnd80(logic signed [MUL_P_W-1:0] v,
                                                      int unsigned n);
    logic signed [MUL_P_W-1:0] half;
    half = $signed({{(MUL_P_W-1){1'b0}}, 1'b1}) <<< (n - 1);
    return (v + half) >>> n;
  endfunction

endpackage

[hw/rtl/odo_mul.sv]
// odo_mul: signed multiplier working over two 16-bit digits of the second operand
`timescale 1ns / 1ps

module odo_mul (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [odo_pkg::MUL_A_W-1:0]   a,
  input  logic signed [odo_pkg::MUL_B_W-1:0]   b,
  output logic                                 done,
  output logic signed [odo_pkg::MUL_P_W-1:0]   p
);

  logic                                 busy_r, busy_nxt;
  logic                                 step_r, step_nxt;
  logic                                 done_r, done_nxt;
  logic signed [odo_pkg::MUL_A_W-1:0]   a_r, a_nxt;
  logic signed [odo_pkg::MUL_B_W-1:0]   b_r, b_nxt;
  logic signed [odo_pkg::MUL_P_W-1:0]   acc_r, acc_nxt;
  logic signed [16:0]                   dig;
  logic signed [odo_pkg::MUL_A_W+16:0]  prod;

  assign dig  = step_r ? $signed({1'b0, b_r[15:0]}) : $signed({b_r[31], b_r[31:16]});
  assign prod = a_r * dig;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 1'b0;
      a_nxt    = a;
      b_nxt    = b;
    end else if (busy_r) begin
      if (!step_r) begin
        acc_nxt  = odo_pkg::MUL_P_W'(prod);
        step_nxt = 1'b1;
      end else begin
        acc_nxt  = (acc_r <<< 16) + odo_pkg::MUL_P_W'(prod);
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

[hw/rtl/odo_div.sv]
// odo_div: unsigned restoring divider, two quotient bits per cycle
`timescale 1ns / 1ps

module odo_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [odo_pkg::DIV_W-1:0]     dvd,
  input  logic [odo_pkg::DIV_D_W-1:0]   dsr,
  input  logic [odo_pkg::DIV_C_W-1:0]   iters,
  output logic                          done,
  output logic [odo_pkg::DIV_W-1:0]     quo,
  output logic [odo_pkg::DIV_D_W-1:0]   rem
);

  localparam int DW = odo_pkg::DIV_D_W;

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [odo_pkg::DIV_C_W-1:0]       cnt_r, cnt_nxt;
  logic [odo_pkg::DIV_W-1:0]         dvd_r, dvd_nxt;
  logic [odo_pkg::DIV_W-1:0]         quo_r, quo_nxt;
  logic [DW-1:0]                     rem_r, rem_nxt;
  logic [DW-1:0]                     dsr_r, dsr_nxt;
  logic [DW:0]                       t1, t2, r1, r2;
  logic                              ge1, ge2;

  always_comb begin
    t1  = {rem_r, dvd_r[odo_pkg::DIV_W-1]};
    ge1 = t1 >= {1'b0, dsr_r};
    r1  = ge1 ? t1 - {1'b0, dsr_r} : t1;
    t2  = {r1[DW-1:0], dvd_r[odo_pkg::DIV_W-2]};
    ge2 = t2 >= {1'b0, dsr_r};
    r2  = ge2 ? t2 - {1'b0, dsr_r} : t2;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = iters;
      dvd_nxt  = dvd;
      quo_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = dsr;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 2;
      quo_nxt = {quo_r[odo_pkg::DIV_W-3:0], ge1, ge2};
      rem_nxt = r2[DW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == odo_pkg::DIV_C_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

[hw/rtl/odo_cordic.sv]
// odo_cordic: rotation-mode cordic, one iteration per cycle
`timescale 1ns / 1ps

module odo_cordic #(
  parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [odo_pkg::COR_Z_W-1:0]  z0,
  output logic                                done,
  output logic signed [odo_pkg::COR_W-1:0]    cos_q30,
  output logic signed [odo_pkg::COR_W-1:0]    sin_q30
);

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int W  = odo_pkg::COR_W;
  localparam int ZW = odo_pkg::COR_Z_W;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [IW-1:0]       i_r, i_nxt;
  logic signed [W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic signed [W-1:0] xsh, ysh;
  logic signed [ZW-1:0] ang;

  assign xsh = x_r >>> i_r;
  assign ysh = y_r >>> i_r;
  assign ang = $signed({1'b0, odo_pkg::atan_q30(5'(i_r))});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    i_nxt    = i_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (start) begin
      busy_nxt = 1'b1;
      i_nxt    = '0;
      x_nxt    = W'(odo_pkg::GAIN_Q30);
      y_nxt    = '0;
      z_nxt    = z0;
    end else if (busy_r) begin
      if (!z_r[ZW-1]) begin
        x_nxt = x_r - ysh;
        y_nxt = y_r + xsh;
        z_nxt = z_r - ang;
      end else begin
        x_nxt = x_r + ysh;
        y_nxt = y_r - xsh;
        z_nxt = z_r + ang;
      end
      i_nxt = i_r + 1'b1;
      if (i_r == IW'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      i_r    <= i_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign done    = done_r;
  assign cos_q30 = x_r;
  assign sin_q30 = y_r;

endmodule

[hw/rtl/odo_dp.sv]
// odo_dp: odometry datapath with pose state, arithmetic units and result register
`timescale 1ns / 1ps

module odo_dp #(
  parameter int CORDIC_STEPS  = odo_pkg::CORDIC_STEPS_DEF,
  parameter int POS_FRAC_BITS = odo_pkg::POS_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  odo_pkg::odo_cmd_t cmd,
  output odo_pkg::odo_sts_t sts,
  input  odo_pkg::odo_in_t  in_data,
  output odo_pkg::odo_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [17:0]       cfg_data
);

  localparam int PW       = odo_pkg::MUL_P_W;
  localparam int DL_SHIFT = 33 - POS_FRAC_BITS;
  localparam logic [odo_pkg::DIV_C_W-1:0] IT_FULL = odo_pkg::DIV_C_W'(32);
  localparam logic [odo_pkg::DIV_C_W-1:0] IT_MOD  = odo_pkg::DIV_C_W'(17);
  localparam logic [odo_pkg::DIV_C_W-1:0] IT_CELL = odo_pkg::DIV_C_W'(16);

  logic [15:0] radius_r;
  logic [17:0] spacing_r;
  logic [7:0]  celldiv_r;

  odo_pkg::odo_in_t  in_r;
  odo_pkg::odo_out_t out_r;

  logic signed [31:0] last_r_r, last_r_nxt, last_l_r, last_l_nxt;
  logic signed [31:0] x_r, x_nxt, y_r, y_nxt, len_r, len_nxt;
  logic signed [31:0] head_r, head_nxt, hdeg_r, hdeg_nxt;
  logic signed [31:0] cellx_r, cellx_nxt, celly_r, celly_nxt;

  logic signed [26:0] sum_r, sum_nxt, diff_r, diff_nxt;
  logic signed [47:0] m1_r, m1_nxt, m2_r, m2_nxt;
  logic               p2neg_r, p2neg_nxt;
  logic [63:0]        p2mag_r, p2mag_nxt;
  logic signed [31:0] dl_r, dl_nxt, dth_r, dth_nxt;
  logic signed [32:0] za_r, za_nxt;
  logic               flip_r, flip_nxt;
  logic signed [33:0] c_r, c_nxt, s_r, s_nxt;

  logic signed [47:0] mul_a;
  logic signed [31:0] mul_b;
  logic               is_mul, is_div, is_cor;
  logic [63:0]        div_dvd;
  logic [18:0]        div_dsr;
  logic [odo_pkg::DIV_C_W-1:0] div_iters;
  logic               mul_done, div_done, cor_done;
  logic signed [PW-1:0] mul_p;
  logic [63:0]        div_quo;
  logic [18:0]        div_rem;
  logic signed [33:0] cor_c, cor_s;

  logic [17:0]        sp_eff;
  logic [7:0]         cd_eff;
  logic signed [32:0] mid, xs, ys, dr, dlft, pr, pl;
  logic [32:0]        mid_mag, x_abs, y_abs;
  logic [31:0]        cx_mag, cy_mag;
  logic signed [20:0] a0, a1, a2;
  logic               fl;
  logic signed [PW-1:0] q_s;
  logic signed [31:0] qc, nh;

  assign cfg_ready = 1'b1;
  assign sp_eff = (spacing_r == '0) ? 18'd1 : spacing_r;
  assign cd_eff = (celldiv_r == '0) ? 8'd1 : celldiv_r;

  always_comb begin
    mid     = 33'(head_r) + 33'(dth_r >>> 1);
    mid_mag = mid[32] ? 33'(-mid) : 33'(mid);
    xs      = 33'(x_r);
    ys      = 33'(y_r);
    x_abs   = xs[32] ? 33'(-xs) : 33'(xs);
    y_abs   = ys[32] ? 33'(-ys) : 33'(ys);
    cx_mag  = 32'(x_abs >> POS_FRAC_BITS);
    cy_mag  = 32'(y_abs >> POS_FRAC_BITS);
  end

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    is_mul    = 1'b0;
    is_div    = 1'b0;
    is_cor    = 1'b0;
    div_dvd   = '0;
    div_dsr   = '0;
    div_iters = '0;
    unique case (cmd.op)
      odo_pkg::OP_SUMMUL: begin
        is_mul = 1'b1;
        mul_a  = 48'(sum_r);
        mul_b  = $signed({16'b0, radius_r});
      end
      odo_pkg::OP_DIFMUL: begin
        is_mul = 1'b1;
        mul_a  = 48'(diff_r);
        mul_b  = $signed({16'b0, radius_r});
      end
      odo_pkg::OP_DLMUL: begin
        is_mul = 1'b1;
        mul_a  = m1_r;
        mul_b  = 32'(odo_pkg::DEG2RAD_Q24);
      end
      odo_pkg::OP_THMUL: begin
        is_mul = 1'b1;
        mul_a  = m2_r;
        mul_b  = 32'(odo_pkg::DEG2RAD_Q24);
      end
      odo_pkg::OP_THDIV: begin
        is_div    = 1'b1;
        div_dvd   = p2mag_r;
        div_dsr   = {1'b0, sp_eff};
        div_iters = IT_FULL;
      end
      odo_pkg::OP_MOD: begin
        is_div    = 1'b1;
        div_dvd   = {1'b0, mid_mag, 30'b0};
        div_dsr   = 19'(odo_pkg::TWO_PI_Q16);
        div_iters = IT_MOD;
      end
      odo_pkg::OP_CORDIC: begin
        is_cor = 1'b1;
      end
      odo_pkg::OP_XMUL: begin
        is_mul = 1'b1;
        mul_a  = 48'(c_r);
        mul_b  = dl_r;
      end
      odo_pkg::OP_YMUL: begin
        is_mul = 1'b1;
        mul_a  = 48'(s_r);
        mul_b  = dl_r;
      end
      odo_pkg::OP_DEGMUL: begin
        is_mul = 1'b1;
        mul_a  = 48'(head_r);
        mul_b  = 32'(odo_pkg::RAD2DEG_Q16);
      end
      odo_pkg::OP_CXDIV: begin
        is_div    = 1'b1;
        div_dvd   = {cx_mag, 32'b0};
        div_dsr   = {11'b0, cd_eff};
        div_iters = IT_CELL;
      end
      odo_pkg::OP_CYDIV: begin
        is_div    = 1'b1;
        div_dvd   = {cy_mag, 32'b0};
        div_dsr   = {11'b0, cd_eff};
        div_iters = IT_CELL;
      end
      odo_pkg::OP_NHMUL: begin
        is_mul = 1'b1;
        mul_a  = 48'(in_r.new_heading_deg);
        mul_b  = 32'(odo_pkg::DEG2RAD_Q24);
      end
      default: begin
        is_mul = 1'b0;
      end
    endcase
  end

  odo_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start && is_mul),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  odo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start && is_div),
    .dvd   (div_dvd),
    .dsr   (div_dsr),
    .iters (div_iters),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  odo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.start && is_cor),
    .z0      (za_r),
    .done    (cor_done),
    .cos_q30 (cor_c),
    .sin_q30 (cor_s)
  );

  assign sts.cmd  = in_r.cmd;
  assign sts.done = mul_done || div_done || cor_done;

  // angle folding after the 2pi remainder
  always_comb begin
    if (mid[32] && (div_rem != '0)) begin
      a0 = 21'(odo_pkg::TWO_PI_Q16) - $signed({2'b0, div_rem});
    end else begin
      a0 = $signed({2'b0, div_rem});
    end
    a1 = (a0 > 21'(odo_pkg::PI_Q16)) ? a0 - 21'(odo_pkg::TWO_PI_Q16) : a0;
    fl = 1'b0;
    a2 = a1;
    if (a1 > 21'(odo_pkg::HALF_PI_Q16)) begin
      a2 = a1 - 21'(odo_pkg::PI_Q16);
      fl = 1'b1;
    end else if (a1 < -21'(odo_pkg::HALF_PI_Q16)) begin
      a2 = a1 + 21'(odo_pkg::PI_Q16);
      fl = 1'b1;
    end
  end

  always_comb begin
    q_s = p2neg_r ? -$signed({16'b0, div_quo}) : $signed({16'b0, div_quo});
    qc  = $signed(div_quo[31:0]);
    nh  = odo_pkg::sat32(odo_pkg::rnd80(mul_p, 16));
    dr   = 33'(in_r.right_count) - 33'(last_r_r);
    dlft = 33'(in_r.left_count) - 33'(last_l_r);
    pr   = dr;
    pl   = dlft;
    if (dr > 33'(odo_pkg::COUNT_CLAMP)) begin
      pr = 33'(odo_pkg::COUNT_CLAMP);
    end else if (dr < -33'(odo_pkg::COUNT_CLAMP)) begin
      pr = -33'(odo_pkg::COUNT_CLAMP);
    end
    if (dlft > 33'(odo_pkg::COUNT_CLAMP)) begin
      pl = 33'(odo_pkg::COUNT_CLAMP);
    end else if (dlft < -33'(odo_pkg::COUNT_CLAMP)) begin
      pl = -33'(odo_pkg::COUNT_CLAMP);
    end
  end

  always_comb begin
    last_r_nxt = last_r_r;
    last_l_nxt = last_l_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    len_nxt    = len_r;
    head_nxt   = head_r;
    hdeg_nxt   = hdeg_r;
    cellx_nxt  = cellx_r;
    celly_nxt  = celly_r;
    sum_nxt    = sum_r;
    diff_nxt   = diff_r;
    m1_nxt     = m1_r;
    m2_nxt     = m2_r;
    p2neg_nxt  = p2neg_r;
    p2mag_nxt  = p2mag_r;
    dl_nxt     = dl_r;
    dth_nxt    = dth_r;
    za_nxt     = za_r;
    flip_nxt   = flip_r;
    c_nxt      = c_r;
    s_nxt      = s_r;
    if (cmd.load) begin
      unique case (in_r.cmd)
        odo_pkg::CMD_UPDATE: begin
          sum_nxt    = 27'(pr + pl);
          diff_nxt   = 27'(pr - pl);
          last_r_nxt = in_r.right_count;
          last_l_nxt = in_r.left_count;
        end
        odo_pkg::CMD_INIT: begin
          x_nxt      = '0;
          y_nxt      = '0;
          len_nxt    = '0;
          head_nxt   = '0;
          hdeg_nxt   = '0;
          cellx_nxt  = '0;
          celly_nxt  = '0;
          last_r_nxt = in_r.right_count;
          last_l_nxt = in_r.left_count;
        end
        odo_pkg::CMD_SETLEN: begin
          len_nxt = in_r.new_length;
        end
        default: begin
          len_nxt = len_r;
        end
      endcase
    end
    if (cmd.capture) begin
      unique case (cmd.op)
        odo_pkg::OP_SUMMUL: m1_nxt = 48'(mul_p);
        odo_pkg::OP_DIFMUL: m2_nxt = 48'(mul_p);
        odo_pkg::OP_DLMUL:  dl_nxt = odo_pkg::sat32(odo_pkg::rnd80(mul_p, DL_SHIFT));
        odo_pkg::OP_THMUL: begin
          p2neg_nxt = mul_p[PW-1];
          p2mag_nxt = mul_p[PW-1] ? 64'(-mul_p) : 64'(mul_p);
        end
        odo_pkg::OP_THDIV:  dth_nxt = odo_pkg::sat32(odo_pkg::rnd80(q_s, 8));
        odo_pkg::OP_MOD: begin
          za_nxt   = 33'(a2) <<< 14;
          flip_nxt = fl;
        end
        odo_pkg::OP_CORDIC: begin
          c_nxt = flip_r ? -cor_c : cor_c;
          s_nxt = flip_r ? -cor_s : cor_s;
        end
        odo_pkg::OP_XMUL: begin
          x_nxt    = odo_pkg::sat32(PW'(x_r) + odo_pkg::rnd80(mul_p, 30));
          len_nxt  = odo_pkg::sat32(PW'(len_r) + PW'(dl_r));
          head_nxt = odo_pkg::sat32(PW'(head_r) + PW'(dth_r));
        end
        odo_pkg::OP_YMUL:   y_nxt = odo_pkg::sat32(PW'(y_r) + odo_pkg::rnd80(mul_p, 30));
        odo_pkg::OP_DEGMUL: hdeg_nxt = odo_pkg::sat32(odo_pkg::rnd80(mul_p, 24));
        odo_pkg::OP_CXDIV:  cellx_nxt = x_r[31] ? -qc : qc;
        odo_pkg::OP_CYDIV:  celly_nxt = y_r[31] ? -qc : qc;
        odo_pkg::OP_NHMUL: begin
          if (in_r.correct_mode inside {odo_pkg::MODE_XYH, odo_pkg::MODE_XY,
                                        odo_pkg::MODE_XH}) begin
            x_nxt = in_r.new_x;
          end
          if (in_r.correct_mode inside {odo_pkg::MODE_XYH, odo_pkg::MODE_XY,
                                        odo_pkg::MODE_YH}) begin
            y_nxt = in_r.new_y;
          end
          if (in_r.correct_mode inside {odo_pkg::MODE_XYH, odo_pkg::MODE_XH,
                                        odo_pkg::MODE_YH}) begin
            head_nxt = nh;
          end
        end
        default: begin
          x_nxt = x_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= odo_pkg::RADIUS_RST;
      spacing_r <= odo_pkg::SPACING_RST;
      celldiv_r <= odo_pkg::CELLDIV_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        odo_pkg::CFG_RADIUS:  radius_r  <= cfg_data[15:0];
        odo_pkg::CFG_SPACING: spacing_r <= cfg_data;
        odo_pkg::CFG_CELLDIV: celldiv_r <= cfg_data[7:0];
        default: radius_r <= radius_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r_r <= '0;
      last_l_r <= '0;
      x_r      <= '0;
      y_r      <= '0;
      len_r    <= '0;
      head_r   <= '0;
      hdeg_r   <= '0;
      cellx_r  <= '0;
      celly_r  <= '0;
    end else begin
      last_r_r <= last_r_nxt;
      last_l_r <= last_l_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      len_r    <= len_nxt;
      head_r   <= head_nxt;
      hdeg_r   <= hdeg_nxt;
      cellx_r  <= cellx_nxt;
      celly_r  <= celly_nxt;
    end
    sum_r   <= sum_nxt;
    diff_r  <= diff_nxt;
    m1_r    <= m1_nxt;
    m2_r    <= m2_nxt;
    p2neg_r <= p2neg_nxt;
    p2mag_r <= p2mag_nxt;
    dl_r    <= dl_nxt;
    dth_r   <= dth_nxt;
    za_r    <= za_nxt;
    flip_r  <= flip_nxt;
    c_r     <= c_nxt;
    s_r     <= s_nxt;
    if (cmd.accept) begin
      in_r <= in_data;
    end
    if (cmd.out_load) begin
      out_r <= '{pos_x: x_r, pos_y: y_r, heading_degrees: hdeg_r,
                 travelled: len_r, cell_x: cellx_r, cell_y: celly_r};
    end
  end

  assign out_data = out_r;

endmodule

[hw/rtl/odo_ctrl.sv]
// odo_ctrl: sequencer that steps the datapath through one command
`timescale 1ns / 1ps

module odo_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output odo_pkg::odo_cmd_t cmd,
  input  odo_pkg::odo_sts_t sts
);

  odo_pkg::odo_state_t state_r, state_nxt;
  odo_pkg::odo_op_t    op_r, op_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      odo_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = odo_pkg::ST_LOAD;
        end
      end
      odo_pkg::ST_LOAD: begin
        unique case (sts.cmd)
          odo_pkg::CMD_UPDATE: begin
            op_nxt    = odo_pkg::OP_SUMMUL;
            state_nxt = odo_pkg::ST_ISSUE;
          end
          odo_pkg::CMD_CORRECT: begin
            op_nxt    = odo_pkg::OP_NHMUL;
            state_nxt = odo_pkg::ST_ISSUE;
          end
          default: state_nxt = odo_pkg::ST_FINISH;
        endcase
      end
      odo_pkg::ST_ISSUE: state_nxt = odo_pkg::ST_WAIT;
      odo_pkg::ST_WAIT: begin
        if (sts.done) begin
          if (odo_pkg::op_is_last(op_r)) begin
            state_nxt = odo_pkg::ST_FINISH;
          end else begin
            op_nxt    = odo_pkg::next_op(op_r);
            state_nxt = odo_pkg::ST_ISSUE;
          end
        end
      end
      odo_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = odo_pkg::ST_IDLE;
        end
      end
      default: state_nxt = odo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == odo_pkg::ST_IDLE);
    cmd.accept   = in_valid && (state_r == odo_pkg::ST_IDLE);
    cmd.load     = (state_r == odo_pkg::ST_LOAD);
    cmd.op       = op_r;
    cmd.start    = (state_r == odo_pkg::ST_ISSUE);
    cmd.capture  = (state_r == odo_pkg::ST_WAIT) && sts.done;
    cmd.out_load = (state_r == odo_pkg::ST_FINISH) && (!out_valid_r || out_ready);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= odo_pkg::ST_IDLE;
      op_r        <= odo_pkg::OP_SUMMUL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> state_r == odo_pkg::ST_WAIT)
    else $error("unit finished outside the wait state");

  a_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !sts.done)
    else $error("unit finished one cycle after start");

  a_op_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == odo_pkg::ST_WAIT && !sts.done) |=> $stable(op_r))
    else $error("operation changed while waiting");

endmodule

[hw/rtl/differential_drive_odometry_unit.sv]
// differential_drive_odometry_unit: top level of the wheel odometry block
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    odo_in_t
//   out_     output     out_valid / out_ready  odo_out_t
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an update beat runs the multipliers, the divider (two bits per cycle) and the cordic
// in turn; a correction beat uses the multiplier only, init and set-length beats none
// rst_n is synchronous: pose state and configuration reset together
// one beat is in work at a time; the next beat is taken while a result waits
// in the output register, and a finished result holds until out_ready
`timescale 1ns / 1ps

module differential_drive_odometry_unit #(
  parameter int CORDIC_STEPS  = odo_pkg::CORDIC_STEPS_DEF,
  parameter int POS_FRAC_BITS = odo_pkg::POS_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  odo_pkg::odo_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output odo_pkg::odo_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [17:0]       cfg_data
);

  odo_pkg::odo_cmd_t cmd;
  odo_pkg::odo_sts_t sts;

  odo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  odo_dp #(
    .CORDIC_STEPS  (CORDIC_STEPS),
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

[sim/tb_differential_drive_odometry_unit.sv]
// tb_differential_drive_odometry_unit: self-checking testbench of the wheel odometry unit
`timescale 1ns / 1ps

module tb_differential_drive_odometry_unit;
  import odo_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int HOLD_CYCLES = 400;

  localparam longint ATAN_TAB [30] = '{
    843314857, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149,
    1048576, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64,
    32, 16, 8, 4, 2
  };

  class odo_scoreboard;
    longint radius, spacing, celldiv;
    longint prev_r, prev_l, x, y, len, head, head_deg, cx, cy;
    odo_out_t pose_q[$];
    int errors;

    function new();
      radius = RADIUS_RST;
      spacing = SPACING_RST;
      celldiv = CELLDIV_RST;
      prev_r = 0; prev_l = 0; x = 0; y = 0; len = 0;
      head = 0; head_deg = 0; cx = 0; cy = 0;
      errors = 0;
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint rnd(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function longint clamp_delta(longint v);
      if (v > COUNT_CLAMP) return COUNT_CLAMP;
      if (v < -longint'(COUNT_CLAMP)) return -longint'(COUNT_CLAMP);
      return v;
    endfunction

    function void sin_cos(longint ang, output longint c, output longint s);
      longint a, cx_, cy_, z, nx;
      bit flip;
      a = ang % TWO_PI_Q16;
      cx_ = GAIN_Q30;
      cy_ = 0;
      flip = 0;
      if (a < 0) a += TWO_PI_Q16;
      if (a > PI_Q16) a -= TWO_PI_Q16;
      if (a > HALF_PI_Q16) begin
        a -= PI_Q16;
        flip = 1;
      end else if (a < -longint'(HALF_PI_Q16)) begin
        a += PI_Q16;
        flip = 1;
      end
      z = a * 16384;
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
        if (z >= 0) begin
          nx = cx_ - (cy_ >>> i);
          cy_ = cy_ + (cx_ >>> i);
          z -= ATAN_TAB[i];
        end else begin
          nx = cx_ + (cy_ >>> i);
          cy_ = cy_ - (cx_ >>> i);
          z += ATAN_TAB[i];
        end
        cx_ = nx;
      end
      c = flip ? -cx_ : cx_;
      s = flip ? -cy_ : cy_;
    endfunction

    function void set_cfg(logic [1:0] idx, logic [17:0] val);
      if (idx == CFG_RADIUS) radius = val[15:0];
      else if (idx == CFG_SPACING) spacing = val;
      else if (idx == CFG_CELLDIV) celldiv = val[7:0];
    endfunction

    function void note_input(odo_in_t it);
      longint pr, pl, sp, dl, dth, c, s, dv, nh;
      odo_out_t res;
      case (it.cmd)
        CMD_UPDATE: begin
          pr = clamp_delta(longint'(it.right_count) - prev_r);
          pl = clamp_delta(longint'(it.left_count) - prev_l);
          sp = spacing ? spacing : 1;
          prev_r = it.right_count;
          prev_l = it.left_count;
          dl = sat(rnd(radius * (pr + pl) * DEG2RAD_Q24, 33 - POS_FRAC_BITS_DEF));
          dth = sat(rnd((radius * (pr - pl) * DEG2RAD_Q24) / sp, 8));
          sin_cos(head + (dth >>> 1), c, s);
          x = sat(x + rnd(dl * c, 30));
          y = sat(y + rnd(dl * s, 30));
          len = sat(len + dl);
          head = sat(head + dth);
          head_deg = sat(rnd(head * RAD2DEG_Q16, 24));
          dv = celldiv ? celldiv : 1;
          cx = (x / (64'sd1 <<< POS_FRAC_BITS_DEF)) / dv;
          cy = (y / (64'sd1 <<< POS_FRAC_BITS_DEF)) / dv;
        end
        CMD_INIT: begin
          x = 0; y = 0; len = 0; head = 0; head_deg = 0; cx = 0; cy = 0;
          prev_r = it.right_count;
          prev_l = it.left_count;
        end
        CMD_CORRECT: begin
          nh = sat(rnd(longint'(it.new_heading_deg) * DEG2RAD_Q24, 16));
          if (it.correct_mode inside {MODE_XYH, MODE_XY, MODE_XH}) x = it.new_x;
          if (it.correct_mode inside {MODE_XYH, MODE_XY, MODE_YH}) y = it.new_y;
          if (it.correct_mode inside {MODE_XYH, MODE_XH, MODE_YH}) head = nh;
        end
        default: len = it.new_length;
      endcase
      res.pos_x = x[31:0];
      res.pos_y = y[31:0];
      res.heading_degrees = head_deg[31:0];
      res.travelled = len[31:0];
      res.cell_x = cx[31:0];
      res.cell_y = cy[31:0];
      pose_q.push_back(res);
    endfunction

    function void check_result(odo_out_t got);
      odo_out_t want;
      if (pose_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = pose_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch x %0d/%0d y %0d/%0d deg %0d/%0d",
                   want.pos_x, got.pos_x, want.pos_y, got.pos_y,
                   want.heading_degrees, got.heading_degrees);
          $display("         len %0d/%0d cx %0d/%0d cy %0d/%0d",
                   want.travelled, got.travelled, want.cell_x, got.cell_x,
                   want.cell_y, got.cell_y);
        end
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  odo_in_t in_data;
  odo_out_t out_data;
  logic [1:0] cfg_index;
  logic [17:0] cfg_data;

  odo_scoreboard sb;
  bit quiet;
  int idle_cycles;
  int results_seen;
  longint gen_r, gen_l;

  differential_drive_odometry_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    cfg_valid = 0;
    cfg_index = CFG_RADIUS;
    cfg_data = '0;
    quiet = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off once 60 results have been seen
  initial begin
    bit held;
    int n;
    held = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 60) begin
        held = 1;
        out_ready <= 0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 15);
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
    end
  end

  task automatic send_beat(odo_in_t it);
    int n;
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 15);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 0;
    while (sb.pose_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [17:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_cfg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic odo_in_t noise_beat(logic [1:0] cmd);
    odo_in_t it;
    it.cmd = cmd;
    it.right_count = $urandom;
    it.left_count = $urandom;
    it.new_x = $urandom;
    it.new_y = $urandom;
    it.new_heading_deg = $urandom;
    it.correct_mode = $urandom_range(0, 7);
    it.new_length = $urandom;
    return it;
  endfunction

  function automatic odo_in_t move_beat(longint dr, longint dlft);
    odo_in_t it;
    it = noise_beat(CMD_UPDATE);
    gen_r = gen_r + dr;
    gen_l = gen_l + dlft;
    it.right_count = gen_r[31:0];
    it.left_count = gen_l[31:0];
    gen_r = it.right_count;
    gen_l = it.left_count;
    return it;
  endfunction

  task automatic directed_beats();
    odo_in_t it;
    it = noise_beat(CMD_INIT);
    it.right_count = 0;
    it.left_count = 0;
    gen_r = 0;
    gen_l = 0;
    send_beat(it);
    send_beat(move_beat(0, 0));
    send_beat(move_beat(360, 360));
    send_beat(move_beat(720, -720));
    send_beat(move_beat(-3000, 1500));
    // count changes past the clamp
    send_beat(move_beat(64'sd2147483647 - gen_r, -64'sd2147483648 - gen_l));
    send_beat(move_beat(-64'sd2147483648 - gen_r, 64'sd2147483647 - gen_l));
    for (int m = 0; m < 8; m++) begin
      it = noise_beat(CMD_CORRECT);
      it.correct_mode = m[2:0];
      it.new_heading_deg = (m % 2) ? 32'sh7fffffff : 32'sh80000000;
      it.new_x = (m % 3 == 0) ? 32'sh7fffffff : 32'sh80000000;
      it.new_y = (m % 3 == 1) ? 32'sh7fffffff : 32'sh80000000;
      send_beat(it);
    end
    send_beat(move_beat(50, 10));
    it = noise_beat(CMD_SETLEN);
    it.new_length = 32'sh7fffffff;
    send_beat(it);
    send_beat(move_beat(5000, 5000));
    it.new_length = 32'sh80000000;
    send_beat(it);
    send_beat(move_beat(-5000, -5000));
    it = noise_beat(CMD_CORRECT);
    it.correct_mode = MODE_XYH;
    it.new_heading_deg = 180 * 256;
    send_beat(it);
    send_beat(move_beat(100, -100));
    it = noise_beat(CMD_INIT);
    it.right_count = 32'sh7fffffff;
    it.left_count = 32'sh80000000;
    gen_r = it.right_count;
    gen_l = it.left_count;
    send_beat(it);
    send_beat(move_beat(1, -1));
  endtask

  task automatic random_beats(int count);
    int pick;
    odo_in_t it;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_beat(move_beat(longint'($urandom_range(0, 4000)) - 2000,
                            longint'($urandom_range(0, 4000)) - 2000));
      end else if (pick < 66) begin
        it = noise_beat(CMD_UPDATE);
        gen_r = it.right_count;
        gen_l = it.left_count;
        send_beat(it);
      end else if (pick < 71) begin
        it = noise_beat(CMD_INIT);
        gen_r = it.right_count;
        gen_l = it.left_count;
        send_beat(it);
      end else if (pick < 88) begin
        it = noise_beat(CMD_CORRECT);
        if ($urandom_range(0, 1)) begin
          it.new_x = $signed($urandom_range(0, 2000000)) - 1000000;
          it.new_y = $signed($urandom_range(0, 2000000)) - 1000000;
          it.new_heading_deg = $signed($urandom_range(0, 400000)) - 200000;
        end
        send_beat(it);
      end else begin
        it = noise_beat(CMD_SETLEN);
        send_beat(it);
      end
    end
  endtask

  initial begin
    gen_r = 0;
    gen_l = 0;
    results_seen = 0;
    idle_cycles = 0;
    @(posedge rst_n);
    @(posedge clk);
    directed_beats();
    random_beats(220);
    drain();
    write_reg(CFG_RADIUS, 18'd1);
    write_reg(CFG_SPACING, 18'd256);
    write_reg(CFG_CELLDIV, 18'd1);
    random_beats(180);
    drain();
    write_reg(CFG_RADIUS, 18'd65535);
    write_reg(CFG_SPACING, 18'd262143);
    write_reg(CFG_CELLDIV, 18'd255);
    random_beats(180);
    drain();
    write_reg(CFG_RADIUS, 18'd0);
    write_reg(CFG_SPACING, 18'd0);
    write_reg(CFG_CELLDIV, 18'd0);
    random_beats(120);
    drain();
    write_reg(CFG_RADIUS, 18'($urandom_range(1, 65535)));
    write_reg(CFG_SPACING, 18'($urandom_range(256, 262143)));
    write_reg(CFG_CELLDIV, 18'($urandom_range(1, 255)));
    random_beats(180);
    drain();
    quiet = 1;
    write_reg(CFG_RADIUS, 18'd12800);
    write_reg(CFG_SPACING, 18'd38400);
    write_reg(CFG_CELLDIV, 18'd3);
    random_beats(150);
    drain();
    if (sb.errors == 0 && sb.pose_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
